### rtl/spam_pkg.sv
// shared types and codes for the sparse polynomial add/merge unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package spam_pkg;

   // default capacity of the term store for polynomial A
   localparam int MAX_TERMS_DEF = 32;
   // width of the term count and read pointer (holds capacity up to 63)
   localparam int CNT_W = 6;

   // request op codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_MERGE  = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // one stored term of A: coefficient in the upper half, exponent in the lower
   typedef struct packed {
      logic [15:0] coef;
      logic [15:0] expo;
   } term_type;

   // one result item
   typedef struct packed {
      logic [16:0] coef;
      logic [15:0] expo;
      logic        term_valid;
      logic        end_of_sum;
      logic        last_of_run;
      logic        overflow;
   } item_type;

   // result handed from the sequencer to the output register
   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

endpackage

`default_nettype wire

### rtl/spam_store.sv
// term store for polynomial A: one write port, one read port, registered read
// depends on spam_pkg
`timescale 1ns / 1ps
`default_nettype none

module spam_store #(
   parameter int MAX_TERMS = spam_pkg::MAX_TERMS_DEF,
   parameter int AW        = 5
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire spam_pkg::term_type wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output spam_pkg::term_type      rd_data
);
   import spam_pkg::*;

   term_type store_ff [MAX_TERMS];
   term_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/spam_seq.sv
// sequencer: request decode, store pointers, merge compare and result staging
// depends on spam_pkg; drives spam_store and the output register of the top level
`timescale 1ns / 1ps
`default_nettype none

module spam_seq #(
   parameter int MAX_TERMS = spam_pkg::MAX_TERMS_DEF,
   parameter int AW        = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [1:0]         req_op,
   input  wire logic [15:0]        req_coefficient,
   input  wire logic [15:0]        req_exponent,
   input  wire logic               slot_free,
   output spam_pkg::push_type      push,
   output      logic               wr_en,
   output      logic [AW-1:0]      wr_addr,
   output spam_pkg::term_type      wr_data,
   output      logic [AW-1:0]      rd_addr,
   input  wire spam_pkg::term_type rd_data
);
   import spam_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_EVAL  = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              ovf_ff, ovf_in;
   logic              merging_ff, merging_in;
   logic [1:0]        op_ff, op_in;
   logic [15:0]       coef_ff, coef_in;
   logic [15:0]       expo_ff, expo_in;
   logic              hold_v_ff, hold_v_in;
   item_type          hold_ff, hold_in;

   logic              have;
   logic              can_act;
   logic              emit_a;
   logic              equal;
   logic [16:0]       sum;
   item_type          a_item;
   item_type          f_item;

   assign have    = ptr_ff < count_ff;
   assign can_act = !hold_v_ff || slot_free;
   assign equal   = have && (rd_data.expo == expo_ff);
   assign emit_a  = (op_ff == OP_FINISH) ? have : (have && (rd_data.expo > expo_ff));
   assign sum     = {rd_data.coef[15], rd_data.coef} + {coef_ff[15], coef_ff};

   always_comb begin
      a_item             = '0;
      a_item.coef        = {rd_data.coef[15], rd_data.coef};
      a_item.expo        = rd_data.expo;
      a_item.term_valid  = 1'b1;
      a_item.overflow    = ovf_ff;
   end

   // closing result of a merge or finish request
   always_comb begin
      f_item          = '0;
      f_item.overflow = ovf_ff;
      if (op_ff == OP_FINISH) begin
         f_item.end_of_sum = 1'b1;
      end else if (equal) begin
         f_item.coef       = sum;
         f_item.expo       = expo_ff;
         f_item.term_valid = 1'b1;
      end else begin
         f_item.coef       = {coef_ff[15], coef_ff};
         f_item.expo       = expo_ff;
         f_item.term_valid = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      ovf_in     = ovf_ff;
      merging_in = merging_ff;
      op_in      = op_ff;
      coef_in    = coef_ff;
      expo_in    = expo_ff;
      hold_v_in  = hold_v_ff;
      hold_in    = hold_ff;
      push       = '0;
      push.item  = hold_ff;
      req_ready  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = '{coef: req_coefficient, expo: req_exponent};

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in   = req_op;
               coef_in = req_coefficient;
               expo_in = req_exponent;
               case (req_op)
                  OP_LOAD: begin
                     if (!merging_ff && (req_coefficient != '0)) begin
                        if (count_ff >= CNT_W'(MAX_TERMS)) begin
                           ovf_in = 1'b1;
                        end else begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  OP_MERGE: begin
                     if (req_coefficient != '0) begin
                        merging_in = 1'b1;
                        state_in   = S_READ;
                     end
                  end
                  OP_FINISH: begin
                     state_in = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (can_act) begin
               if (emit_a) begin
                  push.valid = hold_v_ff;
                  hold_in    = a_item;
                  hold_v_in  = 1'b1;
                  ptr_in     = ptr_ff + CNT_W'(1);
               end else if ((op_ff == OP_MERGE) && equal && (sum == '0)) begin
                  // cancelling sum: the staged term, if any, closes the run
                  ptr_in   = ptr_ff + CNT_W'(1);
                  state_in = hold_v_ff ? S_FLUSH : S_IDLE;
               end else begin
                  push.valid = hold_v_ff;
                  hold_in    = f_item;
                  hold_v_in  = 1'b1;
                  state_in   = S_FLUSH;
                  if (equal) begin
                     ptr_in = ptr_ff + CNT_W'(1);
                  end
                  if (op_ff == OP_FINISH) begin
                     count_in   = '0;
                     ptr_in     = '0;
                     merging_in = 1'b0;
                     ovf_in     = 1'b0;
                  end
               end
            end
         end
         S_FLUSH: begin
            if (slot_free) begin
               push.valid            = 1'b1;
               push.item.last_of_run = 1'b1;
               hold_v_in             = 1'b0;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // read ahead to the next entry while a run of A terms is streaming out
   assign rd_addr = ptr_in[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         ptr_ff     <= '0;
         ovf_ff     <= 1'b0;
         merging_ff <= 1'b0;
         hold_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ptr_ff     <= ptr_in;
         ovf_ff     <= ovf_in;
         merging_ff <= merging_in;
         hold_v_ff  <= hold_v_in;
      end
      op_ff   <= op_in;
      coef_ff <= coef_in;
      expo_ff <= expo_in;
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

### rtl/sparse_polynomial_add_merge_unit.sv
// top level of the sparse polynomial add/merge unit: output register and wiring
// depends on spam_pkg, spam_store and spam_seq
`timescale 1ns / 1ps
`default_nettype none

// usage
//  req channel: op 0 loads a term of A into the store, op 1 merges a term of B,
//  op 2 flushes the rest of A and closes the sum with an end marker
//  rsp channel: sum terms, in descending exponent order when A and B are sent in
//  that order; last_of_run marks the final response of a request, end_of_sum the bare end marker
//  request handling
//  - a load request is accepted in idle and gives no response
//  - a merge or finish request steps through accept, store read, compare
//    and close, releasing one stored A term per cycle while the output can
//    take it; the registered read port of the term store paces the A-term stream
//  - requests that give no response (zero coefficient, op 3) are accepted in idle and dropped
//  reset: synchronous, clears the term count, read pointer, overflow and
//  merge flags and the response valid; store contents need no clearing
//  stall: responses wait in a staging register and the output register; while
//  the output register is full and rsp_ready is low the sequencer holds, and
//  req_ready stays low until the request's last response has left the sequencer
module sparse_polynomial_add_merge_unit #(
   parameter int MAX_TERMS = spam_pkg::MAX_TERMS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [1:0]         req_op,
   input  wire logic signed [15:0] req_coefficient,
   input  wire logic [15:0]        req_exponent,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [16:0] rsp_sum_coefficient,
   output      logic [15:0]        rsp_sum_exponent,
   output      logic               rsp_term_valid,
   output      logic               rsp_end_of_sum,
   output      logic               rsp_last_of_run,
   output      logic               rsp_a_overflow
);
   import spam_pkg::*;

   // store address width; a single-entry store still gets one address bit
   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   push_type          push;
   logic              slot_free;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   term_type          wr_data;
   logic [AW-1:0]     rd_addr;
   term_type          rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   item_type          rsp_item_ff, rsp_item_in;

   spam_store #(
      .MAX_TERMS (MAX_TERMS),
      .AW        (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spam_seq #(
      .MAX_TERMS (MAX_TERMS),
      .AW        (AW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_coefficient (req_coefficient),
      .req_exponent    (req_exponent),
      .slot_free       (slot_free),
      .push            (push),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   // output register frees up in the same cycle its response is taken
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = push.item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sum_coefficient = rsp_item_ff.coef;
   assign rsp_sum_exponent    = rsp_item_ff.expo;
   assign rsp_term_valid      = rsp_item_ff.term_valid;
   assign rsp_end_of_sum      = rsp_item_ff.end_of_sum;
   assign rsp_last_of_run     = rsp_item_ff.last_of_run;
   assign rsp_a_overflow      = rsp_item_ff.overflow;

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench for sparse_polynomial_add_merge_unit: a scoreboard class models
// the ordered merge of the two polynomials, tasks drive the request side, an always block the response side
// depends on spam_pkg and the rtl of the unit
`timescale 1ns / 1ps

// models the term store of A and the merge; holds the responses still to come
class poly_sum_scoreboard;
   spam_pkg::term_type a_terms [spam_pkg::MAX_TERMS_DEF];
   int a_count;
   int a_next;
   bit overflow;
   bit merging;
   spam_pkg::item_type expected_terms [$];
   int errors;
   int checked;
   int sums_closed;
   int overflowed_sums;

   function void push_term(logic [16:0] coef, logic [15:0] expo, bit has_term, bit end_mark);
      spam_pkg::item_type t;
      t.coef        = coef;
      t.expo        = expo;
      t.term_valid  = has_term;
      t.end_of_sum  = end_mark;
      t.last_of_run = 1'b0;
      t.overflow    = overflow;
      expected_terms.push_back(t);
   endfunction

   function void release_a_term();
      push_term({a_terms[a_next].coef[15], a_terms[a_next].coef}, a_terms[a_next].expo,
                1'b1, 1'b0);
      a_next++;
   endfunction

   // works out the responses of one accepted request
   function void note_request(logic [1:0] op, logic [15:0] coef, logic [15:0] expo);
      spam_pkg::item_type t;
      logic [16:0] total;
      int before_count;
      before_count = expected_terms.size();
      case (op)
         spam_pkg::OP_LOAD: begin
            if (!merging && coef != 16'd0) begin
               if (a_count >= spam_pkg::MAX_TERMS_DEF) begin
                  overflow = 1'b1;
               end else begin
                  a_terms[a_count].coef = coef;
                  a_terms[a_count].expo = expo;
                  a_count++;
               end
            end
         end
         spam_pkg::OP_MERGE: begin
            if (coef != 16'd0) begin
               merging = 1'b1;
               while (a_next < a_count && a_terms[a_next].expo > expo) release_a_term();
               if (a_next < a_count && a_terms[a_next].expo == expo) begin
                  total = {a_terms[a_next].coef[15], a_terms[a_next].coef} + {coef[15], coef};
                  a_next++;
                  if (total != 17'd0) push_term(total, expo, 1'b1, 1'b0);
               end else begin
                  push_term({coef[15], coef}, expo, 1'b1, 1'b0);
               end
            end
         end
         spam_pkg::OP_FINISH: begin
            while (a_next < a_count) release_a_term();
            push_term(17'd0, 16'd0, 1'b0, 1'b1);
            a_count  = 0;
            a_next   = 0;
            merging  = 1'b0;
            overflow = 1'b0;
         end
         default: ;
      endcase
      // flag the final response of this request
      if (expected_terms.size() > before_count) begin
         t = expected_terms.pop_back();
         t.last_of_run = 1'b1;
         expected_terms.push_back(t);
      end
   endfunction

   function void compare_field(string name, logic [16:0] want, logic [16:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   function void check_term(spam_pkg::item_type got);
      spam_pkg::item_type want;
      if (expected_terms.size() == 0) begin
         errors++;
         $display("%0t: unexpected response, expected none, actual %h", $time, got);
      end else begin
         want = expected_terms.pop_front();
         checked++;
         compare_field("sum_coefficient", want.coef, got.coef);
         compare_field("sum_exponent", 17'(want.expo), 17'(got.expo));
         compare_field("term_valid", 17'(want.term_valid), 17'(got.term_valid));
         compare_field("end_of_sum", 17'(want.end_of_sum), 17'(got.end_of_sum));
         compare_field("last_of_run", 17'(want.last_of_run), 17'(got.last_of_run));
         compare_field("a_overflow", 17'(want.overflow), 17'(got.overflow));
         if (got.end_of_sum) begin
            sums_closed++;
            if (got.overflow) overflowed_sums++;
         end
      end
   endfunction
endclass

module tb;
   import spam_pkg::*;

   // op code that the unit ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // far above the slowest correct run, including every response stalled
   localparam int CYCLE_LIMIT = 400000;
   // chance in a hundred that a side idles in a cycle
   localparam int IDLE_PCT = 24;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic signed [15:0] req_coefficient;
   logic [15:0] req_exponent;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [16:0] rsp_sum_coefficient;
   logic [15:0] rsp_sum_exponent;
   logic        rsp_term_valid;
   logic        rsp_end_of_sum;
   logic        rsp_last_of_run;
   logic        rsp_a_overflow;

   // no idling on either side while set
   logic        calm = 1'b0;
   int          cycles = 0;
   int          requests_sent = 0;
   int          counted_items = 0;

   poly_sum_scoreboard sum_board;

   sparse_polynomial_add_merge_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_coefficient     (req_coefficient),
      .req_exponent        (req_exponent),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sum_coefficient (rsp_sum_coefficient),
      .rsp_sum_exponent    (rsp_sum_exponent),
      .rsp_term_valid      (rsp_term_valid),
      .rsp_end_of_sum      (rsp_end_of_sum),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_a_overflow      (rsp_a_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side stalls at random, except in the calm stretch
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // every accepted response goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sum_board.check_term(item_type'{rsp_sum_coefficient, rsp_sum_exponent, rsp_term_valid,
                                         rsp_end_of_sum, rsp_last_of_run, rsp_a_overflow});
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("sparse_polynomial_add_merge_unit test failed");
         $finish;
      end
   end

   function automatic logic [15:0] nonzero_coef();
      logic [15:0] c;
      c = 16'($urandom);
      if (c == 16'd0) c = 16'h0001;
      return c;
   endfunction

   // presents one request, with a random gap first, and waits for its acceptance
   task automatic send_request(input logic [1:0] op, input logic [15:0] coef,
                               input logic [15:0] expo);
      int idle;
      idle = 0;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) idle++;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_coefficient <= coef;
      req_exponent    <= expo;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge
      sum_board.note_request(op, coef, expo);
      requests_sent++;
   endtask

   // requests the unit throws away
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0:       send_request(OP_LOAD, 16'd0, 16'($urandom));
         1:       send_request(OP_MERGE, 16'd0, 16'($urandom));
         default: send_request(OP_UNUSED, 16'($urandom), 16'($urandom));
      endcase
   endtask

   // one whole sum: descending A terms, B terms that partly hit them, then finish
   task automatic run_random_sum(input bit fill_store);
      logic [15:0] a_exp [$];
      logic [15:0] a_coef [$];
      logic [15:0] b_exp [$];
      logic [15:0] c;
      int n_a;
      int n_b;
      int top;
      int e;
      int i;
      int j;
      n_a = fill_store ? $urandom_range(MAX_TERMS_DEF + 1, MAX_TERMS_DEF + 4)
                       : $urandom_range(0, 8);
      top = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
      // spread exponents over what is left so they stay strictly descending
      for (i = 0; i < n_a && top >= 0; i++) begin
         e = top - $urandom_range(0, top / (n_a - i));
         a_exp.push_back(16'(e));
         a_coef.push_back(nonzero_coef());
         top = e - 1;
      end

      for (i = 0; i < a_exp.size(); i++) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         send_request(OP_LOAD, a_coef[i], a_exp[i]);
         counted_items++;
      end

      // B exponents: about half land on A terms
      n_b = $urandom_range(0, 6);
      for (i = 0; i < n_b; i++) begin
         if (a_exp.size() > 0 && $urandom_range(0, 1) == 0)
            b_exp.push_back(a_exp[$urandom_range(0, a_exp.size() - 1)]);
         else
            b_exp.push_back(16'($urandom));
      end
      b_exp.rsort();
      // now and then an unsorted B polynomial
      if ($urandom_range(0, 7) == 0) b_exp.shuffle();

      for (i = 0; i < b_exp.size(); i++) begin
         c = nonzero_coef();
         // sometimes the negated A coefficient so the term cancels
         for (j = 0; j < a_exp.size(); j++) begin
            if (a_exp[j] == b_exp[i] && $urandom_range(0, 2) == 0) c = -a_coef[j];
         end
         if ($urandom_range(0, 9) == 0) send_noise();
         // a late load, ignored once merging has begun
         if (i > 0 && $urandom_range(0, 11) == 0)
            send_request(OP_LOAD, nonzero_coef(), 16'($urandom));
         send_request(OP_MERGE, c, b_exp[i]);
         counted_items++;
      end

      // coefficient and exponent of a finish carry no meaning
      send_request(OP_FINISH, 16'($urandom), 16'($urandom));
      counted_items++;
   endtask

   initial begin
      int sum_index;
      sum_board = new;
      req_valid       <= 1'b0;
      req_op          <= OP_LOAD;
      req_coefficient <= 16'sd0;
      req_exponent    <= 16'd0;
      reset           <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // finish with nothing loaded: bare end marker only
      send_request(OP_FINISH, 16'd0, 16'd0);
      // A = 5x^65535 - 32768x^40000 + 32767x^1000 + 100x^500 - 7
      send_request(OP_LOAD, 16'd5, 16'hFFFF);
      send_request(OP_LOAD, 16'h8000, 16'd40000);
      send_request(OP_LOAD, 16'd0, 16'd30000);      // zero coefficient, dropped
      send_request(OP_LOAD, 16'h7FFF, 16'd1000);
      send_request(OP_LOAD, 16'd100, 16'd500);
      send_request(OP_LOAD, 16'hFFF9, 16'd0);
      send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF);   // unused op code
      send_request(OP_MERGE, 16'd12, 16'd50000);    // releases the top A term first
      send_request(OP_MERGE, 16'd0, 16'd45000);     // zero coefficient, dropped
      send_request(OP_MERGE, 16'h7FFF, 16'd40000);  // equal exponent, sum -1
      send_request(OP_LOAD, 16'd9, 16'd20000);      // load while merging
      send_request(OP_MERGE, 16'h8001, 16'd1000);   // cancelling sum, no response
      send_request(OP_MERGE, 16'h7FFF, 16'd500);    // sum above 16 bits
      send_request(OP_FINISH, 16'd0, 16'd0);        // flushes -7, then the marker
      // most negative sum and an unsorted B polynomial
      send_request(OP_LOAD, 16'h8000, 16'hFFFF);
      send_request(OP_LOAD, 16'd1, 16'd2);
      send_request(OP_MERGE, 16'h8000, 16'hFFFF);   // -65536
      send_request(OP_MERGE, 16'd3, 16'd60000);
      send_request(OP_MERGE, 16'd4, 16'd60001);     // out of order
      send_request(OP_MERGE, 16'd5, 16'd0);         // releases x^2 first
      send_request(OP_FINISH, 16'hFFFF, 16'hFFFF);

      // random sums; the second one is sized to overfill the store of A
      sum_index = 0;
      while (requests_sent < 100) begin
         calm <= (counted_items >= 40 && counted_items < 70);
         run_random_sum(sum_index == 1 || $urandom_range(0, 15) == 0);
         sum_index++;
      end
      req_valid <= 1'b0;

      while (sum_board.expected_terms.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d requests sent, %0d responses checked over %0d finished sums",
               requests_sent, sum_board.checked, sum_board.sums_closed);
      $display("%0d sums ended with the A store overflowed", sum_board.overflowed_sums);
      if (sum_board.errors == 0) begin
         $display("sparse_polynomial_add_merge_unit test passed");
      end else begin
         $display("sparse_polynomial_add_merge_unit test failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/spam_pkg.sv
rtl/spam_store.sv
rtl/spam_seq.sv
rtl/sparse_polynomial_add_merge_unit.sv
tb/tb.sv
